/* hdl/mc_step_size_adapter_core_defines.svh */
// ---------------------------------------------------------------------------
// Step size adapter assertion macros
// Shared assertion shapes for the checker; clock and reset are taken from
// the scope that uses the macro (clk, rst_n).
// ---------------------------------------------------------------------------
`ifndef MC_STEP_SIZE_ADAPTER_CORE_DEFINES_SVH
`define MC_STEP_SIZE_ADAPTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MCSSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mc_ssa: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define MCSSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mc_ssa: next-cycle check failed");

`endif

/* hdl/mc_ssa_pkg.sv */
// ---------------------------------------------------------------------------
// Step size adapter package
// Types and constants shared by the channel engine and the top level.
// ---------------------------------------------------------------------------
package mc_ssa_pkg;

    // Clamp limits of the Q1.16 scale factor.
    localparam logic [16:0] FACTOR_HI = 17'd98304;
    localparam logic [16:0] FACTOR_LO = 17'd32768;

    // Iteration counts of the bit-serial units.
    localparam logic [4:0] MUL_T_STEPS = 5'd16;
    localparam logic [4:0] DIV_STEPS   = 5'd17;
    localparam logic [4:0] MUL_S_STEPS = 5'd17;

    // Configuration register indexes (word address bit).
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_BOX    = 1'b1;

    // Channel engine states.
    typedef enum logic [2:0] {
        CH_IDLE,
        CH_MUL_T,
        CH_CMP,
        CH_DIV,
        CH_MUL_S,
        CH_DONE
    } chan_state_t;

    // Top level sequencing states.
    typedef enum logic {
        TOP_IDLE,
        TOP_BUSY
    } top_state_t;

    // Commands from the top level to a channel engine.
    typedef struct packed {
        logic start;
        logic grow;
        logic ack;
    } chan_cmd_t;

    // Status from a channel engine to the top level.
    typedef struct packed {
        logic done;
        logic adjusted;
    } chan_sts_t;

endpackage

/* hdl/mc_ssa_chan.sv */
// ---------------------------------------------------------------------------
// Step size adapter channel engine
// Bit-serial multiply for the denominator, clamp check, restoring divide for
// the scale factor and bit-serial multiply of the step by the factor.
// ---------------------------------------------------------------------------
module mc_ssa_chan
    import mc_ssa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chan_cmd_t   cmd,
    input  logic [31:0] delta_att,
    input  logic [31:0] delta_acc,
    input  logic [31:0] step,
    input  logic [15:0] target,
    output chan_sts_t   sts,
    output logic [31:0] result
);

    chan_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [48:0] acc_reg, acc_next;
    logic [48:0] mcand_reg, mcand_next;
    logic [16:0] mplier_reg, mplier_next;
    logic [47:0] den_reg, den_next;
    logic [47:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [31:0] dn_reg, dn_next;
    logic [31:0] step_reg, step_next;
    logic        adj_reg, adj_next;
    logic [31:0] result_reg, result_next;

    logic [48:0] add_sum;
    logic [48:0] rem_sh;
    logic [48:0] rem_diff;
    logic        rem_ge;
    logic [48:0] num2;
    logic [49:0] den3;
    logic [16:0] quo_new;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dn_reg     <= dn_next;
        step_reg   <= step_next;
        adj_reg    <= adj_next;
        result_reg <= result_next;
    end

    // Shared arithmetic: one accumulate, one trial subtract, the clamp compare operands.
    always_comb
    begin
        add_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : 49'd0);
        rem_sh   = {rem_reg, 1'b0};
        rem_diff = rem_sh - {1'b0, den_reg};
        rem_ge   = (rem_sh >= {1'b0, den_reg});
        num2     = {dn_reg, 17'd0};
        den3     = {2'b00, acc_reg[47:0]} + {1'b0, acc_reg[47:0], 1'b0};
        quo_new  = {quo_reg[15:0], rem_ge};
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dn_next     = dn_reg;
        step_next   = step_reg;
        adj_next    = adj_reg;
        result_next = result_reg;

        unique case (state_reg)
            CH_IDLE:
            begin
                if (cmd.start)
                begin
                    step_next = step;
                    dn_next   = delta_acc;
                    adj_next  = cmd.grow;
                    if (cmd.grow)
                    begin
                        acc_next    = '0;
                        mcand_next  = {17'd0, delta_att};
                        mplier_next = {1'b0, target};
                        cnt_next    = MUL_T_STEPS;
                        state_next  = CH_MUL_T;
                    end
                    else
                    begin
                        result_next = step;
                        state_next  = CH_DONE;
                    end
                end
            end

            // Denominator: attempt delta times target, one target bit a cycle.
            CH_MUL_T:
            begin
                acc_next    = add_sum;
                mcand_next  = {mcand_reg[47:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[16:1]};
                cnt_next    = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = CH_CMP;
                end
            end

            // Clamp check; the divide runs only for factors strictly inside.
            CH_CMP:
            begin
                den_next = acc_reg[47:0];
                if ({1'b0, num2} >= den3)
                begin
                    acc_next    = '0;
                    mcand_next  = {17'd0, step_reg};
                    mplier_next = FACTOR_HI;
                    cnt_next    = MUL_S_STEPS;
                    state_next  = CH_MUL_S;
                end
                else if (num2 <= {1'b0, acc_reg[47:0]})
                begin
                    acc_next    = '0;
                    mcand_next  = {17'd0, step_reg};
                    mplier_next = FACTOR_LO;
                    cnt_next    = MUL_S_STEPS;
                    state_next  = CH_MUL_S;
                end
                else
                begin
                    rem_next   = {1'b0, dn_reg, 15'd0};
                    quo_next   = '0;
                    cnt_next   = DIV_STEPS;
                    state_next = CH_DIV;
                end
            end

            // Restoring divide, one quotient bit a cycle.
            CH_DIV:
            begin
                rem_next = rem_ge ? rem_diff[47:0] : rem_sh[47:0];
                quo_next = quo_new;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    acc_next    = '0;
                    mcand_next  = {17'd0, step_reg};
                    mplier_next = quo_new;
                    cnt_next    = MUL_S_STEPS;
                    state_next  = CH_MUL_S;
                end
            end

            // Step times factor, one factor bit a cycle, then saturate.
            CH_MUL_S:
            begin
                acc_next    = add_sum;
                mcand_next  = {mcand_reg[47:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[16:1]};
                cnt_next    = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    result_next = add_sum[48] ? 32'hFFFF_FFFF : add_sum[47:16];
                    state_next  = CH_DONE;
                end
            end

            CH_DONE:
            begin
                if (cmd.ack)
                begin
                    state_next = CH_IDLE;
                end
            end

            default:
            begin
                state_next = CH_IDLE;
            end
        endcase
    end

    assign sts.done     = (state_reg == CH_DONE);
    assign sts.adjusted = adj_reg;
    assign result       = result_reg;

endmodule

/* hdl/mc_step_size_adapter_core.sv */
// ---------------------------------------------------------------------------
// Monte Carlo step size adapter
// Adapts the displacement and volume step sizes from acceptance counters.
// ---------------------------------------------------------------------------
// Usage: one input transaction on the s_ channel carries the cumulative
// counters and present steps of both channels; one output transaction on the
// m_ channel returns the new steps, with the recompute flags in m_tuser.
// The user must set target acceptance and box length over the APB port only
// while idle; the block itself does not enforce it. Each channel has its own
// engine: a bit-serial multiply, a clamp compare, a restoring divide (skipped
// when the factor clamps) and a bit-serial multiply. Only one item is in work
// at a time. The next item is accepted as soon as the result is registered,
// even while the receiver stalls it; a result waiting in the output register
// blocks only the delivery of the following one. Reset clears the recorded
// counters and loads target 0.5 and box length 10.0.
// ---------------------------------------------------------------------------
module mc_step_size_adapter_core
    import mc_ssa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Input item: move_attempts, move_accepts, volume_attempts,
    // volume_accepts, current_displacement, current_volume_step (low first)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,
    // Result item: new_displacement, new_volume_step (low first)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,
    // Result flags: displacement_adjusted, volume_adjusted (low first)
    output logic [1:0]   m_tuser,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    top_state_t  state_reg, state_next;
    logic [15:0] target_reg;
    logic [31:0] box_reg;
    logic [31:0] last_matt_reg, last_macc_reg, last_vatt_reg, last_vacc_reg;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    logic [31:0] move_att, move_acc, vol_att, vol_acc, cur_disp, cur_vol;
    logic        in_take;
    logic        cfg_wr;
    chan_cmd_t   disp_cmd, vol_cmd;
    chan_sts_t   disp_sts, vol_sts;
    logic [31:0] disp_res, vol_res;
    logic [31:0] disp_da, disp_dn, vol_da, vol_dn;
    logic [31:0] cap;
    logic [31:0] disp_final;
    logic        both_done;
    logic        out_load;

    assign move_att = s_tdata[31:0];
    assign move_acc = s_tdata[63:32];
    assign vol_att  = s_tdata[95:64];
    assign vol_acc  = s_tdata[127:96];
    assign cur_disp = s_tdata[159:128];
    assign cur_vol  = s_tdata[191:160];

    assign in_take = s_tvalid && s_tready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 16'd32768;
            box_reg    <= 32'd655360;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_TARGET: target_reg <= pwdata[15:0];
                REG_BOX:    box_reg    <= pwdata;
                default:    box_reg    <= box_reg;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[2])
            REG_TARGET: prdata = {16'd0, target_reg};
            REG_BOX:    prdata = box_reg;
            default:    prdata = '0;
        endcase
    end

    // Counter deltas against the recorded values.
    always_comb
    begin
        disp_da = move_att - last_matt_reg;
        disp_dn = (move_acc >= last_macc_reg) ? (move_acc - last_macc_reg)
                                              : (last_macc_reg - move_acc);
        vol_da  = vol_att - last_vatt_reg;
        vol_dn  = (vol_acc >= last_vacc_reg) ? (vol_acc - last_vacc_reg)
                                             : (last_vacc_reg - vol_acc);
    end

    // Recorded counters, updated on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_matt_reg <= '0;
            last_macc_reg <= '0;
            last_vatt_reg <= '0;
            last_vacc_reg <= '0;
        end
        else if (in_take)
        begin
            last_matt_reg <= move_att;
            last_macc_reg <= move_acc;
            last_vatt_reg <= vol_att;
            last_vacc_reg <= vol_acc;
        end
    end

    assign both_done = disp_sts.done && vol_sts.done;
    assign out_load  = (state_reg == TOP_BUSY) && both_done
                       && (!out_valid_reg || m_tready);

    always_comb
    begin
        disp_cmd.start = in_take;
        disp_cmd.grow  = (move_att != 32'd0) && (last_matt_reg < move_att);
        disp_cmd.ack   = out_load;
        vol_cmd.start  = in_take;
        vol_cmd.grow   = (vol_att != 32'd0) && (last_vatt_reg < vol_att);
        vol_cmd.ack    = out_load;
    end

    mc_ssa_chan u_disp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (disp_cmd),
        .delta_att (disp_da),
        .delta_acc (disp_dn),
        .step      (cur_disp),
        .target    (target_reg),
        .sts       (disp_sts),
        .result    (disp_res)
    );

    mc_ssa_chan u_vol (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (vol_cmd),
        .delta_att (vol_da),
        .delta_acc (vol_dn),
        .step      (cur_vol),
        .target    (target_reg),
        .sts       (vol_sts),
        .result    (vol_res)
    );

    // Displacement cap at half the box length, recomputed results only.
    always_comb
    begin
        cap        = {1'b0, box_reg[31:1]};
        disp_final = (disp_sts.adjusted && (disp_res > cap)) ? cap : disp_res;
    end

    // Sequencing and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        s_tready       = (state_reg == TOP_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            TOP_IDLE:
            begin
                if (in_take)
                begin
                    state_next = TOP_BUSY;
                end
            end
            TOP_BUSY:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {vol_res, disp_final};
                    out_user_next  = {vol_sts.adjusted, disp_sts.adjusted};
                    state_next     = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* hdl/mc_ssa_checker.sv */
// ---------------------------------------------------------------------------
// Step size adapter port checker
// Watches the top level's ports for sequencing and handshake slips.
// ---------------------------------------------------------------------------
`include "mc_step_size_adapter_core_defines.svh"

module mc_ssa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);

    // The configuration port never inserts wait states.
    `MCSSA_ASSERT_IMP(a_pready_high, 1'b1, pready)

    // One item at a time: the input closes right after a transaction.
    `MCSSA_ASSERT_NXT(a_in_closes, s_tvalid && s_tready, !s_tready)

    // A new result appears only while an item was in work.
    `MCSSA_ASSERT_IMP(a_result_from_work, $rose(m_tvalid), $past(!s_tready))

    // A stalled result holds its payload.
    `MCSSA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind mc_step_size_adapter_core mc_ssa_checker u_mc_ssa_checker (.*);
